// File: hw/rtl/sliding_dft_resonance_correction_macros.svh
// Assertion macros for the sliding DFT resonance correction block.
// Included by modules that check their own control logic; needs clk and rst_n in scope.
`ifndef SLIDING_DFT_RESONANCE_CORRECTION_MACROS_SVH
`define SLIDING_DFT_RESONANCE_CORRECTION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define SDRC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define SDRC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDRC_ASSERT_IMP(name, ante, cons, msg)
`define SDRC_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

// File: hw/rtl/sdrc_pkg.sv
// Shared types, constants and helper functions of the sliding DFT resonance correction.
// Used by sliding_dft_resonance_correction and the testbench; depends on nothing else.
package sdrc_pkg;

    // Default sizes
    localparam int DEF_MAX_BINS  = 16;
    localparam int DEF_MAX_BATCH = 1024;
    localparam int DEF_COEF_BITS = 16;

    // Data formats
    localparam int SUM_W      = 40;
    localparam int ACC_W      = 60;
    localparam int TOT_W      = 48;
    localparam int SAMPLE_W   = 18;
    localparam int DIFF_W     = 19;
    localparam int OUT_W      = 20;
    localparam int ACC_FRAC   = 4;
    localparam int NORM_FRAC  = 15;
    localparam int MUL_A_W    = 21;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = 38;
    localparam int SPLIT      = 20;
    localparam int TERM_W     = 5;
    localparam logic [TERM_W-1:0] LAST_TERM = 5'd16;

    // Register reset values
    localparam logic [10:0] RST_BATCH = 11'd1024;
    localparam logic [4:0]  RST_BINS  = 5'd16;
    localparam logic [15:0] RST_NORM  = 16'd64;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_BATCH = 2'd0;
    localparam logic [1:0] REG_BINS  = 2'd1;
    localparam logic [1:0] REG_NORM  = 2'd2;

    // Commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Coefficient word selects within a bin
    localparam logic [2:0] CS_TW_RE   = 3'd0;
    localparam logic [2:0] CS_TW_IM   = 3'd1;
    localparam logic [2:0] CS_AMP_RE  = 3'd2;
    localparam logic [2:0] CS_AMP_IM  = 3'd3;
    localparam logic [2:0] CS_SUP_SIN = 3'd4;
    localparam logic [2:0] CS_SUP_COS = 3'd5;
    localparam logic [2:0] CS_SHF_SIN = 3'd6;
    localparam logic [2:0] CS_SHF_COS = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_BIN_RD, ST_BIN_LD, ST_MUL_LO, ST_MUL_HI,
        ST_DRAIN, ST_CAPT, ST_DONE
    } state_t;

    // Multiplier operand A sources
    typedef enum logic [3:0] {
        SRC_RE_A, SRC_IM_A, SRC_RE_P, SRC_IM_P, SRC_NAR, SRC_NAI,
        SRC_TR, SRC_TI, SRC_E
    } src_t;

    // Destinations of a finished sum of products
    typedef enum logic [2:0] {
        DST_NAR, DST_NAI, DST_NPR, DST_NPI, DST_TR, DST_TI, DST_E, DST_TOTAL
    } dst_t;

    // One product term of the per-bin microprogram
    typedef struct packed {
        src_t       src;
        logic [2:0] csel;
        logic       use_norm;
        logic       neg;
        logic       first;
        logic       last;
        dst_t       dst;
    } term_t;

    // Tag that travels with a registered partial product
    typedef struct packed {
        logic vld;
        logic hi;
        logic neg;
        logic first;
        logic norm;
    } mac_tag_t;

    // Per-bin microprogram: seventeen product terms in eight sums
    function automatic term_t micro_term(input logic [TERM_W-1:0] idx);
        term_t t;
        unique case (idx)
            5'd0:  t = '{SRC_RE_A, CS_TW_RE,   1'b0, 1'b0, 1'b1, 1'b0, DST_NAR};
            5'd1:  t = '{SRC_IM_A, CS_TW_IM,   1'b0, 1'b1, 1'b0, 1'b1, DST_NAR};
            5'd2:  t = '{SRC_RE_A, CS_TW_IM,   1'b0, 1'b0, 1'b1, 1'b0, DST_NAI};
            5'd3:  t = '{SRC_IM_A, CS_TW_RE,   1'b0, 1'b0, 1'b0, 1'b1, DST_NAI};
            5'd4:  t = '{SRC_RE_P, CS_TW_RE,   1'b0, 1'b0, 1'b1, 1'b0, DST_NPR};
            5'd5:  t = '{SRC_IM_P, CS_TW_IM,   1'b0, 1'b1, 1'b0, 1'b1, DST_NPR};
            5'd6:  t = '{SRC_RE_P, CS_TW_IM,   1'b0, 1'b0, 1'b1, 1'b0, DST_NPI};
            5'd7:  t = '{SRC_IM_P, CS_TW_RE,   1'b0, 1'b0, 1'b0, 1'b1, DST_NPI};
            5'd8:  t = '{SRC_NAR,  CS_AMP_RE,  1'b0, 1'b0, 1'b1, 1'b0, DST_TR};
            5'd9:  t = '{SRC_NAI,  CS_AMP_IM,  1'b0, 1'b1, 1'b0, 1'b1, DST_TR};
            5'd10: t = '{SRC_NAR,  CS_AMP_IM,  1'b0, 1'b0, 1'b1, 1'b0, DST_TI};
            5'd11: t = '{SRC_NAI,  CS_AMP_RE,  1'b0, 1'b0, 1'b0, 1'b1, DST_TI};
            5'd12: t = '{SRC_TR,   CS_SHF_SIN, 1'b0, 1'b0, 1'b1, 1'b0, DST_E};
            5'd13: t = '{SRC_TI,   CS_SHF_COS, 1'b0, 1'b0, 1'b0, 1'b0, DST_E};
            5'd14: t = '{SRC_TR,   CS_SUP_SIN, 1'b0, 1'b1, 1'b0, 1'b0, DST_E};
            5'd15: t = '{SRC_TI,   CS_SUP_COS, 1'b0, 1'b1, 1'b0, 1'b1, DST_E};
            5'd16: t = '{SRC_E,    CS_TW_RE,   1'b1, 1'b0, 1'b1, 1'b1, DST_TOTAL};
            // past the end: wrap to the first term for prefetch
            default: t = '{SRC_RE_A, CS_TW_RE, 1'b0, 1'b0, 1'b1, 1'b0, DST_NAR};
        endcase
        return t;
    endfunction

    // Saturate an accumulator value to a bank sum
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi_lim;
        logic signed [ACC_W-1:0] lo_lim;
        hi_lim = ACC_W'({1'b0, {(SUM_W-1){1'b1}}});
        lo_lim = ~hi_lim;
        if (v > hi_lim)
            return {1'b0, {(SUM_W-1){1'b1}}};
        else if (v < lo_lim)
            return {1'b1, {(SUM_W-1){1'b0}}};
        else
            return v[SUM_W-1:0];
    endfunction

    // Saturate the corrected total to the output width
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [TOT_W-1:0] v);
        logic signed [TOT_W-1:0] hi_lim;
        logic signed [TOT_W-1:0] lo_lim;
        hi_lim = TOT_W'({1'b0, {(OUT_W-1){1'b1}}});
        lo_lim = ~hi_lim;
        if (v > hi_lim)
            return {1'b0, {(OUT_W-1){1'b1}}};
        else if (v < lo_lim)
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return v[OUT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/sliding_dft_resonance_correction.sv
// Sliding DFT resonance correction: sequencer, shared multiply-accumulate unit and memories.
// Depends on sdrc_pkg and sliding_dft_resonance_correction_macros.svh.
//
// A coefficient load (command 1) is written into the table while the block stays idle.
// A sample (command 0) runs, for every bin in use, seventeen complex-update and
// projection products through one 21 x 17 bit signed multiplier, two partial
// products per 40-bit operand, each sum then draining through the 60-bit
// accumulator before its result is kept.
// The request side stalls for the whole sample; the finished item waits in an
// output register, so the next item is accepted while it is still held.
// Bank sums clear at once through per-entry valid bits; history entries never
// written read as zero through a fill count, so no clearing pass follows reset.
`include "sliding_dft_resonance_correction_macros.svh"

module sliding_dft_resonance_correction #(
    parameter int MAX_BINS  = sdrc_pkg::DEF_MAX_BINS,
    parameter int MAX_BATCH = sdrc_pkg::DEF_MAX_BATCH,
    parameter int COEF_BITS = sdrc_pkg::DEF_COEF_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               command,
    input  logic signed [17:0] sample,
    input  logic [3:0]         bin_index,
    input  logic [2:0]         coef_select,
    input  logic signed [15:0] coef_value,
    // result channel
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [19:0] corrected
);

    localparam int BIN_W      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W      = BIN_W + 1;
    localparam int POS_W      = $clog2(MAX_BATCH);
    localparam int FILL_W     = $clog2(MAX_BATCH + 1);
    localparam int LEN_W      = (POS_W + 1 > 11) ? POS_W + 1 : 11;
    localparam int CW         = (COEF_BITS < 16) ? COEF_BITS : 16;
    localparam int CF         = COEF_BITS - 2;
    localparam int NSH        = sdrc_pkg::NORM_FRAC + sdrc_pkg::ACC_FRAC;
    localparam int COEF_DEPTH = (2 ** BIN_W) * 8;
    localparam int SUM_DEPTH  = 2 * (2 ** BIN_W);
    localparam int SW         = sdrc_pkg::SUM_W;
    localparam int AW         = sdrc_pkg::ACC_W;
    localparam int TW         = sdrc_pkg::TOT_W;

    localparam logic signed [AW-1:0] HALF_CF = AW'(1) << (CF - 1);
    localparam logic signed [AW-1:0] HALF_N  = AW'(1) << (NSH - 1);

    // configuration registers
    logic [10:0] batch_len_reg;
    logic [4:0]  bins_reg;
    logic [15:0] norm_reg;

    // control
    sdrc_pkg::state_t state_reg, state_next;
    logic [sdrc_pkg::TERM_W-1:0] term_reg;
    logic [CNT_W-1:0]            bin_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [FILL_W-1:0]           fill_reg;
    logic                        bank_reg;
    logic [SUM_DEPTH-1:0]        sum_vld_reg;
    logic                        res_valid_reg;
    sdrc_pkg::mac_tag_t          tag_reg;

    // datapath
    logic signed [17:0]  x_reg;
    logic signed [18:0]  d_reg;
    logic signed [SW-1:0] re_a_reg, im_a_reg, re_p_reg, im_p_reg;
    logic signed [SW-1:0] nar_reg, nai_reg, npr_reg, tr_reg, ti_reg, e_reg;
    logic signed [TW-1:0] total_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [sdrc_pkg::PROD_W-1:0] prod_reg;
    logic signed [19:0]  corrected_reg;

    // memories
    logic [CW-1:0]       coef_mem [COEF_DEPTH];
    logic [CW-1:0]       coef_rd_reg;
    logic [2*SW-1:0]     sum_mem [SUM_DEPTH];
    logic [2*SW-1:0]     sum_rd_a_reg, sum_rd_p_reg;
    logic signed [17:0]  hist_mem [MAX_BATCH];
    logic signed [17:0]  hist_rd_reg;

    // combinational
    logic               accept;
    logic               out_free;
    logic               cfg_we;
    logic [CNT_W-1:0]   nb;
    logic [LEN_W-1:0]   len;
    logic               batch_end;
    sdrc_pkg::term_t    cur_term, nxt_term;
    logic [2:0]         csel;
    logic [BIN_W:0]     addr_a, addr_p;
    logic signed [SW-1:0] op_a;
    logic signed [sdrc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [sdrc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [sdrc_pkg::PROD_W-1:0]  prod;
    logic signed [AW-1:0] addend, acc_base, acc_next;
    logic signed [AW-1:0] acc_sh_cf, acc_sh_n;
    logic signed [SW-1:0] res_cf;
    logic signed [SW-1:0] sa_re, sa_im, sp_re, sp_im;
    logic signed [17:0]  hist_val;
    logic                coef_we;
    logic                sum_we;
    logic [BIN_W:0]      sum_waddr;
    logic [2*SW-1:0]     sum_wdata;

    assign pready    = 1'b1;
    assign req_stall = (state_reg != sdrc_pkg::ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign corrected = corrected_reg;
    assign cfg_we    = psel && penable && pwrite && pready;

    // Register readback
    always_comb
    begin
        unique case (paddr[3:2])
            sdrc_pkg::REG_BATCH: prdata = {21'd0, batch_len_reg};
            sdrc_pkg::REG_BINS:  prdata = {27'd0, bins_reg};
            sdrc_pkg::REG_NORM:  prdata = {16'd0, norm_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_len_reg <= sdrc_pkg::RST_BATCH;
            bins_reg      <= sdrc_pkg::RST_BINS;
            norm_reg      <= sdrc_pkg::RST_NORM;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                sdrc_pkg::REG_BATCH: batch_len_reg <= pwdata[10:0];
                sdrc_pkg::REG_BINS:  bins_reg      <= pwdata[4:0];
                sdrc_pkg::REG_NORM:  norm_reg      <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    // Clamp bin count and batch length
    always_comb
    begin
        if (32'(bins_reg) > 32'(MAX_BINS))
            nb = CNT_W'(MAX_BINS);
        else
            nb = CNT_W'(bins_reg);
        if (batch_len_reg < 11'd2)
            len = LEN_W'(2);
        else if (32'(batch_len_reg) > 32'(MAX_BATCH))
            len = LEN_W'(MAX_BATCH);
        else
            len = LEN_W'(batch_len_reg);
        batch_end = (LEN_W'(pos_reg) + LEN_W'(1)) >= len;
    end

    // Microprogram decode and coefficient prefetch address
    always_comb
    begin
        cur_term = sdrc_pkg::micro_term(term_reg);
        nxt_term = sdrc_pkg::micro_term(term_reg + 5'd1);
        if (state_reg == sdrc_pkg::ST_MUL_LO || state_reg == sdrc_pkg::ST_BIN_RD
            || state_reg == sdrc_pkg::ST_BIN_LD)
            csel = cur_term.csel;
        else
            csel = nxt_term.csel;
        addr_a = {bank_reg, bin_reg[BIN_W-1:0]};
        addr_p = {~bank_reg, bin_reg[BIN_W-1:0]};
    end

    // Shared multiplier: pick operand, split into halves
    always_comb
    begin
        unique case (cur_term.src)
            sdrc_pkg::SRC_RE_A: op_a = re_a_reg;
            sdrc_pkg::SRC_IM_A: op_a = im_a_reg;
            sdrc_pkg::SRC_RE_P: op_a = re_p_reg;
            sdrc_pkg::SRC_IM_P: op_a = im_p_reg;
            sdrc_pkg::SRC_NAR:  op_a = nar_reg;
            sdrc_pkg::SRC_NAI:  op_a = nai_reg;
            sdrc_pkg::SRC_TR:   op_a = tr_reg;
            sdrc_pkg::SRC_TI:   op_a = ti_reg;
            sdrc_pkg::SRC_E:    op_a = e_reg;
            default:            op_a = '0;
        endcase
        if (state_reg == sdrc_pkg::ST_MUL_HI)
            mul_a = {op_a[SW-1], op_a[SW-1:sdrc_pkg::SPLIT]};
        else
            mul_a = {1'b0, op_a[sdrc_pkg::SPLIT-1:0]};
        if (cur_term.use_norm)
            mul_b = {1'b0, norm_reg};
        else
            mul_b = {{(sdrc_pkg::MUL_B_W-CW){coef_rd_reg[CW-1]}}, coef_rd_reg};
        prod = mul_a * mul_b;
    end

    // Accumulate the registered partial product, seeded with the rounding half
    always_comb
    begin
        addend = AW'(prod_reg);
        if (tag_reg.hi)
            addend = addend <<< sdrc_pkg::SPLIT;
        if (tag_reg.first)
            acc_base = tag_reg.norm ? HALF_N : HALF_CF;
        else
            acc_base = acc_reg;
        if (!tag_reg.vld)
            acc_next = acc_reg;
        else if (tag_reg.neg)
            acc_next = acc_base - addend;
        else
            acc_next = acc_base + addend;
        acc_sh_cf = acc_reg >>> CF;
        acc_sh_n  = acc_reg >>> NSH;
        res_cf    = sdrc_pkg::sat_sum(acc_sh_cf);
    end

    // Bank sums as read, zero where cleared
    always_comb
    begin
        sa_re = sum_vld_reg[addr_a] ? sum_rd_a_reg[2*SW-1:SW] : '0;
        sa_im = sum_vld_reg[addr_a] ? sum_rd_a_reg[SW-1:0]    : '0;
        sp_re = sum_vld_reg[addr_p] ? sum_rd_p_reg[2*SW-1:SW] : '0;
        sp_im = sum_vld_reg[addr_p] ? sum_rd_p_reg[SW-1:0]    : '0;
        hist_val = (FILL_W'(pos_reg) < fill_reg) ? hist_rd_reg : '0;
    end

    // Memory write strobes
    always_comb
    begin
        coef_we = accept && (command == sdrc_pkg::CMD_LOAD)
                  && (32'(bin_index) < 32'(MAX_BINS));
        sum_we    = 1'b0;
        sum_waddr = addr_a;
        sum_wdata = {nar_reg, res_cf};
        if (state_reg == sdrc_pkg::ST_CAPT)
        begin
            if (cur_term.dst == sdrc_pkg::DST_NAI)
                sum_we = 1'b1;
            else if (cur_term.dst == sdrc_pkg::DST_NPI)
            begin
                sum_we    = 1'b1;
                sum_waddr = addr_p;
                sum_wdata = {npr_reg, res_cf};
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdrc_pkg::ST_IDLE:
                if (accept && command == sdrc_pkg::CMD_SAMPLE)
                    state_next = sdrc_pkg::ST_DIFF;
            sdrc_pkg::ST_DIFF:
                state_next = (nb == '0) ? sdrc_pkg::ST_DONE : sdrc_pkg::ST_BIN_RD;
            sdrc_pkg::ST_BIN_RD:
                state_next = sdrc_pkg::ST_BIN_LD;
            sdrc_pkg::ST_BIN_LD:
                state_next = sdrc_pkg::ST_MUL_LO;
            sdrc_pkg::ST_MUL_LO:
                state_next = sdrc_pkg::ST_MUL_HI;
            sdrc_pkg::ST_MUL_HI:
                state_next = cur_term.last ? sdrc_pkg::ST_DRAIN : sdrc_pkg::ST_MUL_LO;
            sdrc_pkg::ST_DRAIN:
                state_next = sdrc_pkg::ST_CAPT;
            sdrc_pkg::ST_CAPT:
                if (term_reg != sdrc_pkg::LAST_TERM)
                    state_next = sdrc_pkg::ST_MUL_LO;
                else if (bin_reg + CNT_W'(1) == nb)
                    state_next = sdrc_pkg::ST_DONE;
                else
                    state_next = sdrc_pkg::ST_BIN_RD;
            sdrc_pkg::ST_DONE:
                if (out_free)
                    state_next = sdrc_pkg::ST_IDLE;
            default:
                state_next = sdrc_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdrc_pkg::ST_IDLE;
            term_reg      <= '0;
            bin_reg       <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            bank_reg      <= 1'b0;
            sum_vld_reg   <= '0;
            res_valid_reg <= 1'b0;
            tag_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // tag the product issued this cycle
            tag_reg.vld   <= (state_reg == sdrc_pkg::ST_MUL_LO)
                             || (state_reg == sdrc_pkg::ST_MUL_HI);
            tag_reg.hi    <= (state_reg == sdrc_pkg::ST_MUL_HI);
            tag_reg.neg   <= cur_term.neg;
            tag_reg.first <= cur_term.first && (state_reg == sdrc_pkg::ST_MUL_LO);
            tag_reg.norm  <= cur_term.use_norm;

            // advance term and bin
            if (state_reg == sdrc_pkg::ST_DIFF)
            begin
                term_reg <= '0;
                bin_reg  <= '0;
            end
            else if (state_reg == sdrc_pkg::ST_MUL_HI && !cur_term.last)
                term_reg <= term_reg + 5'd1;
            else if (state_reg == sdrc_pkg::ST_CAPT)
            begin
                if (term_reg != sdrc_pkg::LAST_TERM)
                    term_reg <= term_reg + 5'd1;
                else
                begin
                    term_reg <= '0;
                    bin_reg  <= bin_reg + CNT_W'(1);
                end
            end

            // mark written bank sums
            if (sum_we)
                sum_vld_reg[sum_waddr] <= 1'b1;

            // finish the item: history pointer, batch end, result
            if (state_reg == sdrc_pkg::ST_DONE && out_free)
            begin
                if (FILL_W'(pos_reg) == fill_reg)
                    fill_reg <= fill_reg + FILL_W'(1);
                if (batch_end)
                begin
                    pos_reg  <= '0;
                    bank_reg <= ~bank_reg;
                    for (int i = 0; i < 2 ** BIN_W; i++)
                        sum_vld_reg[{bank_reg, BIN_W'(i)}] <= 1'b0;
                end
                else
                    pos_reg <= pos_reg + POS_W'(1);
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        acc_reg  <= acc_next;

        if (accept && command == sdrc_pkg::CMD_SAMPLE)
            x_reg <= sample;

        if (state_reg == sdrc_pkg::ST_DIFF)
        begin
            d_reg     <= 19'(x_reg) - 19'(hist_val);
            total_reg <= '0;
        end

        // add the new sample terms to both banks
        if (state_reg == sdrc_pkg::ST_BIN_LD)
        begin
            re_a_reg <= sdrc_pkg::sat_sum(AW'(sa_re) + (AW'(d_reg) <<< sdrc_pkg::ACC_FRAC));
            im_a_reg <= sa_im;
            re_p_reg <= sdrc_pkg::sat_sum(AW'(sp_re) + (AW'(x_reg) <<< sdrc_pkg::ACC_FRAC));
            im_p_reg <= sp_im;
        end

        // keep a finished sum
        if (state_reg == sdrc_pkg::ST_CAPT)
        begin
            unique case (cur_term.dst)
                sdrc_pkg::DST_NAR:   nar_reg <= res_cf;
                sdrc_pkg::DST_NAI:   nai_reg <= res_cf;
                sdrc_pkg::DST_NPR:   npr_reg <= res_cf;
                sdrc_pkg::DST_NPI:   ;
                sdrc_pkg::DST_TR:    tr_reg  <= res_cf;
                sdrc_pkg::DST_TI:    ti_reg  <= res_cf;
                sdrc_pkg::DST_E:     e_reg   <= res_cf;
                sdrc_pkg::DST_TOTAL: total_reg <= total_reg + acc_sh_n[TW-1:0];
                default:             ;
            endcase
        end

        if (state_reg == sdrc_pkg::ST_DONE && out_free)
            corrected_reg <= sdrc_pkg::sat_out(TW'(x_reg) + total_reg);
    end

    // Coefficient table
    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[{BIN_W'(bin_index), coef_select}] <= coef_value[CW-1:0];
        coef_rd_reg <= coef_mem[{bin_reg[BIN_W-1:0], csel}];
    end

    // Bank sums, two read ports
    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_waddr] <= sum_wdata;
        sum_rd_a_reg <= sum_mem[addr_a];
        sum_rd_p_reg <= sum_mem[addr_p];
    end

    // Sample history
    always_ff @(posedge clk)
    begin
        if (state_reg == sdrc_pkg::ST_DONE && out_free)
            hist_mem[pos_reg] <= x_reg;
        hist_rd_reg <= hist_mem[pos_reg];
    end

    // Checks
    `SDRC_ASSERT_IMP(a_res_from_done, $rose(res_valid_reg), $past(state_reg) == sdrc_pkg::ST_DONE, "result raised outside finish")
    `SDRC_ASSERT_IMP(a_pos_within_fill, 1'b1, FILL_W'(pos_reg) <= fill_reg, "history pointer beyond filled part")
    `SDRC_ASSERT_NXT(a_load_stays_idle, accept && command == sdrc_pkg::CMD_LOAD, state_reg == sdrc_pkg::ST_IDLE, "coefficient load left idle")
    `SDRC_ASSERT_IMP(a_capture_drained, state_reg == sdrc_pkg::ST_CAPT, !tag_reg.vld, "product pending at capture")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the sliding DFT resonance correction block.
// Depends on sdrc_pkg and the sliding_dft_resonance_correction RTL; drives items
// and APB writes, predicts every corrected value and checks it in order.
`timescale 1ns / 100ps

module testbench;

    localparam int N_BINS     = 16;
    localparam int N_HIST     = 1024;
    localparam int WORDS      = 8;
    localparam int COEF_SHIFT = 14;
    localparam int DRAIN_CYC  = 900;

    typedef struct {
        logic               cmd;
        logic signed [17:0] smp;
        logic [3:0]         bin;
        logic [2:0]         sel;
        logic signed [15:0] val;
    } req_item_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               req_valid;
    logic               req_stall;
    logic               command;
    logic signed [17:0] sample;
    logic [3:0]         bin_index;
    logic [2:0]         coef_select;
    logic signed [15:0] coef_value;
    logic               res_valid;
    logic               res_stall;
    logic signed [19:0] corrected;

    sliding_dft_resonance_correction u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_stall(req_stall), .command(command),
        .sample(sample), .bin_index(bin_index), .coef_select(coef_select),
        .coef_value(coef_value),
        .res_valid(res_valid), .res_stall(res_stall), .corrected(corrected)
    );

    // Predictor state: shadow registers and memories of the block
    longint    coef_tab [N_BINS*WORDS];
    longint    sum_re [2*N_BINS];
    longint    sum_im [2*N_BINS];
    longint    hist [N_HIST];
    int        hist_pos;
    int        bank;
    int        cfg_batch;
    int        cfg_bins;
    int        cfg_norm;

    req_item_t          pending_items [$];
    logic signed [19:0] expected_corr [$];
    bit        req_taken;
    bit        no_idle;
    int        req_gap;
    int        res_gap;
    int        mismatches;
    int        results_seen;
    int        samples_sent;
    int        loads_sent;

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint sat_to(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Round half up, then floor
    function automatic longint round_shr(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    task automatic twiddle_mul(input longint re, input longint im, input longint wr,
                               input longint wi, output longint ore, output longint oim);
        ore = sat_to(round_shr(re * wr - im * wi, COEF_SHIFT), sdrc_pkg::SUM_W);
        oim = sat_to(round_shr(re * wi + im * wr, COEF_SHIFT), sdrc_pkg::SUM_W);
    endtask

    // Work out the corrected value an item causes, if any
    task automatic predict_corrected(input req_item_t it, output bit has,
                                     output logic signed [19:0] y);
        longint x;
        longint d;
        longint total;
        longint re;
        longint im;
        longint tr;
        longint ti;
        longint e;
        int     nb;
        int     len;
        int     pa;
        int     pp;
        int     base;
        has = 1'b0;
        y = '0;
        if (it.cmd == sdrc_pkg::CMD_LOAD)
        begin
            coef_tab[it.bin*WORDS + it.sel] = longint'(it.val);
            return;
        end
        has = 1'b1;
        x = longint'(it.smp);
        nb = (cfg_bins > N_BINS) ? N_BINS : cfg_bins;
        len = (cfg_batch < 2) ? 2 : ((cfg_batch > N_HIST) ? N_HIST : cfg_batch);
        if (hist_pos >= N_HIST)
            hist_pos = 0;
        d = x - hist[hist_pos];
        pa = bank * N_BINS;
        pp = (bank ^ 1) * N_BINS;
        total = 0;
        for (int i = 0; i < nb; i++)
        begin
            base = i * WORDS;
            re = sat_to(sum_re[pa+i] + d * 16, sdrc_pkg::SUM_W);
            im = sum_im[pa+i];
            twiddle_mul(re, im, coef_tab[base+sdrc_pkg::CS_TW_RE],
                        coef_tab[base+sdrc_pkg::CS_TW_IM], sum_re[pa+i], sum_im[pa+i]);
            re = sat_to(sum_re[pp+i] + x * 16, sdrc_pkg::SUM_W);
            im = sum_im[pp+i];
            twiddle_mul(re, im, coef_tab[base+sdrc_pkg::CS_TW_RE],
                        coef_tab[base+sdrc_pkg::CS_TW_IM], sum_re[pp+i], sum_im[pp+i]);
            twiddle_mul(sum_re[pa+i], sum_im[pa+i], coef_tab[base+sdrc_pkg::CS_AMP_RE],
                        coef_tab[base+sdrc_pkg::CS_AMP_IM], tr, ti);
            e = (coef_tab[base+sdrc_pkg::CS_SHF_SIN] * tr
                 + coef_tab[base+sdrc_pkg::CS_SHF_COS] * ti)
              - (coef_tab[base+sdrc_pkg::CS_SUP_SIN] * tr
                 + coef_tab[base+sdrc_pkg::CS_SUP_COS] * ti);
            e = sat_to(round_shr(e, COEF_SHIFT), sdrc_pkg::SUM_W);
            total += round_shr(e * longint'(cfg_norm),
                               sdrc_pkg::NORM_FRAC + sdrc_pkg::ACC_FRAC);
        end
        y = 20'(sat_to(x + total, sdrc_pkg::OUT_W));
        hist[hist_pos] = x;
        hist_pos++;
        if (hist_pos >= len)
        begin
            hist_pos = 0;
            for (int i = 0; i < N_BINS; i++)
            begin
                sum_re[pa+i] = 0;
                sum_im[pa+i] = 0;
            end
            bank ^= 1;
        end
    endtask

    // Gap length: mostly none or short, a few long
    function automatic int draw_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(200, 20);
    endfunction

    // Record accepted items and predict their results
    always @(posedge clk)
    begin
        bit                 has;
        logic signed [19:0] y;
        req_item_t          it;
        if (rst_n && req_valid && !req_stall)
        begin
            it.cmd = command;
            it.smp = sample;
            it.bin = bin_index;
            it.sel = coef_select;
            it.val = coef_value;
            predict_corrected(it, has, y);
            if (has)
                expected_corr.insert(expected_corr.size(), y);
            req_taken = 1'b1;
        end
    end

    // Driver: present the next pending item after a random gap
    always @(negedge clk)
    begin
        req_item_t it;
        bit        next_valid;
        next_valid = req_valid;
        if (!req_valid || req_taken)
        begin
            req_taken = 1'b0;
            next_valid = 1'b0;
            if (req_gap > 0)
                req_gap--;
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                command <= it.cmd;
                sample <= it.smp;
                bin_index <= it.bin;
                coef_select <= it.sel;
                coef_value <= it.val;
                next_valid = 1'b1;
                req_gap = draw_gap();
            end
        end
        req_valid <= next_valid;
    end

    // Result side: stall at random
    always @(negedge clk)
    begin
        if (res_gap > 0)
        begin
            res_gap--;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
            res_gap = draw_gap();
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        logic signed [19:0] want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (expected_corr.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result corrected=%0d", corrected);
            end
            else
            begin
                want = expected_corr.pop_front();
                if (corrected !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d corrected expected %0d got %0d",
                                 results_seen, want, corrected);
                end
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == sdrc_pkg::REG_BATCH)
            cfg_batch = value & 32'h7FF;
        else if (idx == sdrc_pkg::REG_BINS)
            cfg_bins = value & 32'h1F;
        else if (idx == sdrc_pkg::REG_NORM)
            cfg_norm = value & 32'hFFFF;
    endtask

    task automatic push_sample(input logic signed [17:0] s);
        req_item_t it;
        it.cmd = sdrc_pkg::CMD_SAMPLE;
        it.smp = s;
        it.bin = 4'($urandom);
        it.sel = 3'($urandom);
        it.val = 16'($urandom);
        pending_items.insert(pending_items.size(), it);
        samples_sent++;
    endtask

    task automatic push_load(input logic [3:0] b, input logic [2:0] s,
                             input logic signed [15:0] v);
        req_item_t it;
        it.cmd = sdrc_pkg::CMD_LOAD;
        it.smp = 18'($urandom);
        it.bin = b;
        it.sel = s;
        it.val = v;
        pending_items.insert(pending_items.size(), it);
        loads_sent++;
    endtask

    // Hold until everything sent has been checked and the block has settled
    task automatic wait_idle();
        while (pending_items.size() > 0 || req_valid || expected_corr.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic logic signed [17:0] rand_sample();
        int r;
        r = $urandom_range(9);
        if (r < 5)
            return 18'($urandom);
        if (r < 8)
            return 18'($signed($urandom_range(4000)) - 2000);
        return r[0] ? 18'sh1FFFF : -18'sh20000;
    endfunction

    // Random phase: mostly samples with some coefficient reloads
    task automatic random_phase(input int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 12)
                push_load(4'($urandom), 3'($urandom), 16'($urandom));
            else
                push_sample(rand_sample());
        end
        wait_idle();
    endtask

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_valid = 1'b0;
        res_stall = 1'b0;
        command = sdrc_pkg::CMD_SAMPLE;
        sample = '0;
        bin_index = '0;
        coef_select = '0;
        coef_value = '0;
        req_taken = 1'b0;
        req_gap = 0;
        res_gap = 0;
        no_idle = 1'b0;
        mismatches = 0;
        results_seen = 0;
        samples_sent = 0;
        loads_sent = 0;
        for (int i = 0; i < N_BINS*WORDS; i++)
            coef_tab[i] = 0;
        for (int i = 0; i < 2*N_BINS; i++)
        begin
            sum_re[i] = 0;
            sum_im[i] = 0;
        end
        for (int i = 0; i < N_HIST; i++)
            hist[i] = 0;
        hist_pos = 0;
        bank = 0;
        cfg_batch = sdrc_pkg::RST_BATCH;
        cfg_bins = sdrc_pkg::RST_BINS;
        cfg_norm = sdrc_pkg::RST_NORM;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Fill the whole coefficient table before any sample reads it
        for (int b = 0; b < N_BINS; b++)
            for (int s = 0; s < WORDS; s++)
                push_load(4'(b), 3'(s), 16'($urandom));
        wait_idle();

        // Directed: reset configuration, extreme samples and coefficients
        push_sample(18'sh1FFFF);
        push_sample(-18'sh20000);
        push_sample(18'sd0);
        push_sample(-18'sd1);
        push_load(4'd0, sdrc_pkg::CS_TW_RE, 16'sh7FFF);
        push_load(4'd0, sdrc_pkg::CS_TW_IM, -16'sh8000);
        push_load(4'd15, sdrc_pkg::CS_AMP_RE, 16'sh7FFF);
        push_load(4'd15, sdrc_pkg::CS_SHF_COS, -16'sh8000);
        push_sample(18'sh1FFFF);
        push_sample(18'sh1FFFF);
        push_sample(-18'sh20000);
        wait_idle();

        // Shortest batch, one bin, full-scale norm: banks swap every two samples
        apb_write(sdrc_pkg::REG_BATCH, 32'd2);
        apb_write(sdrc_pkg::REG_BINS, 32'd1);
        apb_write(sdrc_pkg::REG_NORM, 32'd32768);
        push_load(4'd0, sdrc_pkg::CS_TW_RE, 16'sh4000);
        push_load(4'd0, sdrc_pkg::CS_TW_IM, 16'sh0000);
        push_load(4'd0, sdrc_pkg::CS_AMP_RE, 16'sh4000);
        push_load(4'd0, sdrc_pkg::CS_SHF_SIN, 16'sh7FFF);
        for (int k = 0; k < 8; k++)
            push_sample(k[0] ? 18'sh1FFFF : -18'sh20000);
        wait_idle();

        // Batch 0 saturates to 2; bins 0 means no bins processed
        apb_write(sdrc_pkg::REG_BATCH, 32'd0);
        apb_write(sdrc_pkg::REG_BINS, 32'd0);
        apb_write(sdrc_pkg::REG_NORM, 32'hFFFF);
        no_idle = 1'b1;
        random_phase(150);
        no_idle = 1'b0;

        // Batch 1 saturates to 2
        apb_write(sdrc_pkg::REG_BATCH, 32'd1);
        apb_write(sdrc_pkg::REG_BINS, 32'd3);
        apb_write(sdrc_pkg::REG_NORM, 32'd0);
        random_phase(200);

        // Odd batch lengths with a few bins
        apb_write(sdrc_pkg::REG_BATCH, 32'd5);
        apb_write(sdrc_pkg::REG_BINS, 32'd4);
        apb_write(sdrc_pkg::REG_NORM, 32'd16384);
        random_phase(250);

        // Lower the batch length mid-batch
        apb_write(sdrc_pkg::REG_BATCH, 32'd3);
        apb_write(sdrc_pkg::REG_BINS, 32'd2);
        apb_write(sdrc_pkg::REG_NORM, 32'($urandom_range(32768)));
        random_phase(250);

        // Too many bins saturates to all bins; batch above maximum saturates
        apb_write(sdrc_pkg::REG_BATCH, 32'h7FF);
        apb_write(sdrc_pkg::REG_BINS, 32'd31);
        apb_write(sdrc_pkg::REG_NORM, 32'd64);
        random_phase(60);

        // Full-length batch, all bins
        apb_write(sdrc_pkg::REG_BATCH, 32'd1024);
        apb_write(sdrc_pkg::REG_BINS, 32'd16);
        random_phase(50);

        // Random settings, small bin counts
        for (int p = 0; p < 4; p++)
        begin
            apb_write(sdrc_pkg::REG_BATCH, 32'($urandom_range(40, 2)));
            apb_write(sdrc_pkg::REG_BINS, 32'($urandom_range(6, 1)));
            apb_write(sdrc_pkg::REG_NORM, 32'($urandom));
            no_idle = (p == 2);
            random_phase(160);
        end
        no_idle = 1'b0;

        $display("Run covered %0d samples and %0d coefficient loads, %0d results checked,",
                 samples_sent, loads_sent, results_seen);
        $display("over batch lengths 2 to 1024 and 0 to 16 bins in use.");
        if (mismatches == 0 && expected_corr.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Timeout
    initial
    begin
        #100ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sdrc_pkg.sv
hw/rtl/sliding_dft_resonance_correction.sv
dv/testbench.sv
